### src/cpsc_pkg.sv
// Shared types and field widths for the common prefix sum counter.
package cpsc_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned MATCH_W = 13;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    localparam logic CMD_A = 1'b0;
    localparam logic CMD_B = 1'b1;

endpackage

### src/cpsc_store.sv
// Prefix sum store: one write port, one read port with registered read data.
module cpsc_store
    import cpsc_pkg::*;
#(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [SUM_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [SUM_W-1:0]  rd_data
);

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/common_prefix_sum_counter.sv
// Top level: counts prefix sums shared by sequence A and sequence B.
//
//   channel | dir | contents
//   s_      | in  | tdata = value[15:0]; tuser = command (0 A, 1 B); tlast = last
//   m_      | out | tdata = match_count[12:0], no_solution[13], zero pad [15:14]
//
// An A request's prefix sum is written to the store on acceptance while the store has room.
// A B request walks the stored A sums it steps over, reading one store entry per cycle
// through the registered store read port.
// A B request with tlast then loads the result, held until m_ is free.
// aresetn clears all control and run state; store contents stay undefined until written.
// A waiting result does not block A requests or B requests without tlast.
module common_prefix_sum_counter
    import cpsc_pkg::*;
#(
    parameter int unsigned DEPTH = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // value[15:0]
    input  logic                s_tuser,   // command
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // match_count[12:0], no_solution[13]
);

    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] a_count_reg, a_count_next;
    logic [CNT_W-1:0] walk_index_reg, walk_index_next;
    logic [CNT_W-1:0] matches_reg, matches_next;
    logic [SUM_W-1:0] a_total_reg, a_total_next;
    logic [SUM_W-1:0] b_total_reg, b_total_next;
    logic             overflowed_reg, overflowed_next;
    logic             last_reg, last_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic             accept;
    logic             wr_en;
    logic [SUM_W-1:0] rd_data;
    logic             fail;
    logic [SUM_W-1:0] a_sum;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign a_sum    = a_total_reg + SUM_W'(s_tdata[VALUE_W-1:0]);
    assign wr_en    = accept && (s_tuser == CMD_A) && (a_count_reg < CNT_W'(DEPTH));
    assign fail     = (a_total_reg != b_total_reg) || (matches_reg == '0) || overflowed_reg;

    cpsc_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (a_count_reg[ADDR_W-1:0]),
        .wr_data (a_sum),
        .rd_addr (walk_index_next[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        a_count_next    = a_count_reg;
        walk_index_next = walk_index_reg;
        matches_next    = matches_reg;
        a_total_next    = a_total_reg;
        b_total_next    = b_total_reg;
        overflowed_next = overflowed_reg;
        last_next       = last_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == CMD_A) begin
                        a_total_next = a_sum;
                        if (wr_en) begin
                            a_count_next = a_count_reg + 1'b1;
                        end else begin
                            overflowed_next = 1'b1;
                        end
                    end else begin
                        b_total_next = b_total_reg + SUM_W'(s_tdata[VALUE_W-1:0]);
                        last_next    = s_tlast;
                        state_next   = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (walk_index_reg < a_count_reg && rd_data < b_total_reg) begin
                    walk_index_next = walk_index_reg + 1'b1;
                end else begin
                    if (walk_index_reg < a_count_reg && rd_data == b_total_reg) begin
                        matches_next    = matches_reg + 1'b1;
                        walk_index_next = walk_index_reg + 1'b1;
                    end
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[MATCH_W] = fail;
                    m_tdata_next[MATCH_W-1:0] = fail ? '0 : MATCH_W'(matches_reg);
                    a_count_next    = '0;
                    walk_index_next = '0;
                    matches_next    = '0;
                    a_total_next    = '0;
                    b_total_next    = '0;
                    overflowed_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            a_count_reg    <= '0;
            walk_index_reg <= '0;
            matches_reg    <= '0;
            a_total_reg    <= '0;
            b_total_reg    <= '0;
            overflowed_reg <= 1'b0;
            last_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            a_count_reg    <= a_count_next;
            walk_index_reg <= walk_index_next;
            matches_reg    <= matches_next;
            a_total_reg    <= a_total_next;
            b_total_reg    <= b_total_next;
            overflowed_reg <= overflowed_next;
            last_reg       <= last_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_index_reg <= a_count_reg)
        else $error("walk pointer passed stored count");

    a_match_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        matches_reg <= walk_index_reg)
        else $error("more matches than walked entries");

    a_walk_store_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |=> (a_count_reg == $past(a_count_reg)))
        else $error("store count changed during walk");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result raised outside emit");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[MATCH_W]) |-> (m_tdata_reg[MATCH_W-1:0] == '0))
        else $error("failed result carries a nonzero count");

endmodule

### tb/common_prefix_sum_counter_test.sv
// Self-checking testbench for the common prefix sum counter with random stimulus and stalls.
`timescale 1ns / 1ps

module common_prefix_sum_counter_test
    import cpsc_pkg::*;
();

    localparam int unsigned DEPTH = 4096;

    typedef struct {
        logic               cmd;
        logic [VALUE_W-1:0] value;
        logic               last;
        int unsigned        gap;
    } request_t;

    typedef struct {
        logic [MATCH_W-1:0] count;
        logic               no_solution;
    } tally_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    request_t    pending_reqs[$];
    request_t    in_flight;
    tally_t      due_tallies[$];
    int unsigned idle_run;
    int unsigned hold_cycles;
    int unsigned ready_roll;
    bit          squeezed;
    bit          gappy;

    // running image of the block state
    logic [SUM_W-1:0] a_sums [DEPTH];
    int unsigned      a_len;
    int unsigned      walk;
    int unsigned      hits;
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;
    bit               a_full;

    int unsigned a_reqs;
    int unsigned b_reqs;
    int unsigned tallies_seen;
    int unsigned fail_tallies;
    int unsigned full_runs;
    int unsigned top_count;
    int unsigned mismatches;

    common_prefix_sum_counter #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #10 aclk = ~aclk;

    task automatic clear_run();
        a_len  = 0;
        walk   = 0;
        hits   = 0;
        sum_a  = '0;
        sum_b  = '0;
        a_full = 1'b0;
    endtask

    task automatic fold_request(input request_t r);
        tally_t t;
        if (r.cmd == CMD_A) begin
            a_reqs++;
            sum_a = sum_a + r.value;
            if (a_len < DEPTH) begin
                a_sums[a_len] = sum_a;
                a_len++;
            end else begin
                a_full = 1'b1;
            end
        end else begin
            b_reqs++;
            sum_b = sum_b + r.value;
            while (walk < a_len && a_sums[walk] < sum_b) walk++;
            if (walk < a_len && a_sums[walk] == sum_b) begin
                hits++;
                walk++;
            end
            if (r.last) begin
                t.no_solution = (sum_a != sum_b) || (hits == 0) || a_full;
                t.count = t.no_solution ? '0 : hits[MATCH_W-1:0];
                if (t.no_solution) fail_tallies++;
                if (a_full) full_runs++;
                if (!t.no_solution && hits > top_count) top_count = hits;
                due_tallies.push_back(t);
                clear_run();
            end
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!gappy) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned pick_value(input int unsigned mode);
        int unsigned roll;
        if (mode == 0) return $urandom_range(0, 3);
        if (mode == 1) return $urandom_range(0, 60);
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return 65535;
        return $urandom_range(0, 65535);
    endfunction

    task automatic push_req(input logic cmd, input int unsigned value, input logic last);
        request_t r;
        r.cmd   = cmd;
        r.value = value[VALUE_W-1:0];
        r.last  = last;
        r.gap   = pick_gap();
        pending_reqs.push_back(r);
    endtask

    // one pair of sequences, mostly well formed, sometimes broken or noisy
    task automatic gen_run();
        int unsigned kind;
        int unsigned mode;
        int unsigned n_a;
        int unsigned zero_steps;
        int unsigned v;
        longint      a_sum;
        longint      pos;
        longint      target;
        longint      step;
        longint      room;
        longint      nxt;
        int unsigned a_vals[$];
        longint      cuts[$];
        int unsigned b_vals[$];
        kind  = $urandom_range(0, 99);
        mode  = $urandom_range(0, 2);
        gappy = ($urandom_range(0, 3) != 0);
        n_a   = (kind < 8) ? 0 : $urandom_range(1, 24);
        a_sum = 0;
        for (int i = 0; i < n_a; i++) begin
            v = pick_value(mode);
            a_sum += v;
            a_vals.push_back(v);
            cuts.push_back(a_sum);
        end
        if (kind >= 38 && kind < 45) begin
            for (int i = $urandom_range(1, 12); i > 0; i--)
                push_req(1'($urandom_range(0, 1)), pick_value(mode),
                         1'($urandom_range(0, 1)));
            push_req(CMD_B, pick_value(mode), 1'b1);
            return;
        end
        for (int i = 0; i < n_a; i++)
            push_req(CMD_A, a_vals[i],
                     (i == n_a - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0));
        if (kind < 8 || (kind >= 20 && kind < 28)) begin
            for (int i = $urandom_range(1, 10); i > 0; i--) b_vals.push_back(pick_value(mode));
        end else begin
            target = a_sum;
            if (kind < 20) begin
                if (a_sum > 0 && $urandom_range(0, 1) == 1)
                    target = a_sum - $urandom_range(1, (a_sum < 200) ? int'(a_sum) : 200);
                else
                    target = a_sum + $urandom_range(1, 200);
            end
            pos = 0;
            zero_steps = 0;
            do begin
                room = target - pos;
                if (room > 65535) room = 65535;
                nxt = -1;
                foreach (cuts[j]) if (nxt < 0 && cuts[j] > pos) nxt = cuts[j];
                if (room == 0) begin
                    step = 0;
                end else if (nxt >= 0 && nxt - pos <= room && $urandom_range(0, 3) != 0) begin
                    step = nxt - pos;
                end else if (zero_steps < 4 && $urandom_range(0, 5) == 0) begin
                    step = 0;
                    zero_steps++;
                end else begin
                    step = $urandom_range(1, int'(room));
                end
                pos += step;
                b_vals.push_back(int'(step));
            end while (pos < target);
        end
        foreach (b_vals[j]) begin
            push_req(CMD_B, b_vals[j], j == b_vals.size() - 1);
            if (kind >= 28 && kind < 38 && j < b_vals.size() - 1 && $urandom_range(0, 3) == 0)
                push_req(CMD_A, pick_value(mode), 1'($urandom_range(0, 1)));
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            idle_run = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                fold_request(in_flight);
                idle_run = 0;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && idle_run >= pending_reqs[0].gap) begin
                    in_flight = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= in_flight.value;
                    s_tuser  <= in_flight.cmd;
                    s_tlast  <= in_flight.last;
                end else begin
                    s_tvalid <= 1'b0;
                    idle_run++;
                end
            end
        end
    end

    // result receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cycles = 0;
        end else begin
            if (!squeezed && tallies_seen >= 20) begin
                hold_cycles = 300;
                squeezed = 1'b1;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                ready_roll = $urandom_range(0, 99);
                if (ready_roll < 75) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    hold_cycles = (ready_roll < 96) ? $urandom_range(0, 2)
                                                    : $urandom_range(8, 30);
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        tally_t t;
        if (aresetn && m_tvalid && m_tready) begin
            tallies_seen++;
            if (due_tallies.size() == 0) begin
                $error("unexpected result: tdata %h", m_tdata);
                mismatches++;
            end else begin
                t = due_tallies.pop_front();
                if (m_tdata[MATCH_W-1:0] !== t.count) begin
                    $error("match_count: expected %0d, got %0d", t.count, m_tdata[MATCH_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[MATCH_W] !== t.no_solution) begin
                    $error("no_solution: expected %0d, got %0d", t.no_solution, m_tdata[MATCH_W]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int unsigned base;
        clear_run();
        gappy = 1'b1;
        // directed: extremes, lone B, differing totals, late A, duplicate sums
        push_req(CMD_A, 0, 1'b0);
        push_req(CMD_A, 65535, 1'b1);
        push_req(CMD_B, 0, 1'b0);
        push_req(CMD_B, 65535, 1'b1);
        push_req(CMD_B, 7, 1'b1);
        push_req(CMD_A, 3, 1'b1);
        push_req(CMD_B, 4, 1'b1);
        push_req(CMD_A, 5, 1'b1);
        push_req(CMD_B, 2, 1'b0);
        push_req(CMD_A, 3, 1'b0);
        push_req(CMD_B, 6, 1'b1);
        push_req(CMD_A, 0, 1'b0);
        push_req(CMD_A, 0, 1'b0);
        push_req(CMD_A, 4, 1'b0);
        push_req(CMD_B, 0, 1'b0);
        push_req(CMD_B, 0, 1'b0);
        push_req(CMD_B, 4, 1'b1);
        push_req(CMD_A, 16'hAAAA, 1'b0);
        push_req(CMD_A, 16'h5555, 1'b1);
        push_req(CMD_B, 16'hFFFF, 1'b1);
        base = pending_reqs.size();
        while (pending_reqs.size() < base + 1800) gen_run();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_reqs.size() != 0 || s_tvalid) @(posedge aclk);
        while (due_tallies.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d A and %0d B requests; checked %0d results (%0d no_solution).",
                 a_reqs, b_reqs, tallies_seen, fail_tallies);
        $display("Largest match count %0d, %0d runs with a full store overflow.",
                 top_count, full_runs);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Timeout: results still pending or requests not accepted.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
